// ===== design/chrr_pkg.sv =====
`default_nettype none

package chrr_pkg;

    // Hash mix constants
    localparam logic [63:0] MIX_K0 = 64'hdbc7_f5af_2198_a8d1;
    localparam logic [63:0] MIX_K1 = 64'h0000_79f9_bae8_bbde;
    localparam logic [63:0] MIX_K2 = 64'h0009_1abe_813a_357d;
    localparam logic [63:0] MIX_K3 = 64'h0000_2776_3eac_5a46;

    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int LIMIT_W = 31;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] op_a;
        logic [WORD_W-1:0] op_b;
    } mul_req_t;

    typedef struct packed {
        logic               start;
        logic [LIMIT_W-1:0] dividend;
        logic [LIMIT_W-1:0] divisor;
    } rem_req_t;

endpackage

`default_nettype wire

// ===== design/chrr_mul64.sv =====
`default_nettype none

// Wrapping 64x64 multiply, low 64 bits only, on one 32x32 multiplier.
// Partial products: lo*lo, lo*hi, hi*lo. Result valid when done is high.
module chrr_mul64 (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire chrr_pkg::mul_req_t req,
    output logic                    done,
    output logic [63:0]             result
);
    import chrr_pkg::*;

    logic [WORD_W-1:0] op_a_reg;
    logic [WORD_W-1:0] op_b_reg;
    logic [WORD_W-1:0] prod_reg;
    logic [WORD_W-1:0] acc_reg;
    logic              busy_reg;
    logic [1:0]        phase_reg;
    logic              done_reg;

    logic [HALF_W-1:0] mul_a;
    logic [HALF_W-1:0] mul_b;
    logic [WORD_W-1:0] prod_next;

    always_comb
    begin
        case (phase_reg)
            2'd0:
            begin
                mul_a = op_a_reg[HALF_W-1:0];
                mul_b = op_b_reg[HALF_W-1:0];
            end
            2'd1:
            begin
                mul_a = op_a_reg[HALF_W-1:0];
                mul_b = op_b_reg[WORD_W-1:HALF_W];
            end
            default:
            begin
                mul_a = op_a_reg[WORD_W-1:HALF_W];
                mul_b = op_b_reg[HALF_W-1:0];
            end
        endcase
    end

    assign prod_next = {{HALF_W{1'b0}}, mul_a} * {{HALF_W{1'b0}}, mul_b};

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= 2'd0;
            end
            else if (busy_reg)
            begin
                phase_reg <= phase_reg + 2'd1;
                if (phase_reg == 2'd3)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath: product registered, then accumulated in the following cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_a_reg <= req.op_a;
            op_b_reg <= req.op_b;
        end
        else if (busy_reg)
        begin
            prod_reg <= prod_next;
            case (phase_reg)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[HALF_W-1:0], {HALF_W{1'b0}}};
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("multiplier restarted while busy");

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg) && $past(phase_reg) == 2'd3)
        else $error("multiplier done without final phase");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("multiplier done held");

endmodule

`default_nettype wire

// ===== design/chrr_rem.sv =====
`default_nettype none

// Restoring remainder, one dividend bit per cycle, MSB first.
module chrr_rem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire chrr_pkg::rem_req_t req,
    output logic                    done,
    output logic [30:0]             remainder
);
    import chrr_pkg::*;

    localparam int CNT_W = $clog2(LIMIT_W);

    logic [LIMIT_W-1:0] rem_reg;
    logic [LIMIT_W-1:0] dvd_reg;
    logic [LIMIT_W-1:0] dvs_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [LIMIT_W:0]   trial;
    logic [LIMIT_W:0]   diff;

    assign trial = {rem_reg, dvd_reg[LIMIT_W-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(LIMIT_W - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            dvd_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[LIMIT_W-2:0], 1'b0};
            if (diff[LIMIT_W])
                rem_reg <= trial[LIMIT_W-1:0];
            else
                rem_reg <= diff[LIMIT_W-1:0];
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

    a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && dvs_reg != '0 |-> rem_reg < dvs_reg)
        else $error("remainder not below divisor");

    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("remainder unit restarted while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("remainder done held");

endmodule

`default_nettype wire

// ===== design/counter_hash_random_ranged.sv =====
`default_nettype none

// Counter-based random generator. Each s_ transaction carries a range limit and gives
// exactly one m_ transaction: the 64-bit counter is hashed by five wrapping 64-bit
// multiplies with XOR/shift mixing, folded to 32 bits (upper half XOR lower half), and the
// counter then steps by one. Limit zero returns the raw word, any other limit returns the
// low 31 bits of the word modulo the limit. Writing cfg_data reloads the counter (reset
// value zero); write it only while no request is in flight. All multiplies share one
// 32x32 multiplier, each product issued to it and handed back in turn; a nonzero limit
// adds a bit-serial remainder (31 steps plus hand-off) after the fold. s_tready is high
// only between requests; a finished result sits in the output register, so the next
// request may be taken while m_tvalid waits for m_tready.
module counter_hash_random_ranged (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [30:0] range_limit, [31] zero pad
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] random_value
    // seed write
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [63:0] cfg_data   // [63:0] seed_value
);
    import chrr_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ISSUE = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_FOLD  = 3'd3;
    localparam logic [2:0] ST_REM   = 3'd4;
    localparam logic [2:0] ST_DONE  = 3'd5;

    // multiply steps of the hash, in order
    localparam logic [2:0] OP_A = 3'd0;  // a = c * K0
    localparam logic [2:0] OP_M = 3'd1;  // m = K3 * (a >> 14)
    localparam logic [2:0] OP_T = 3'd2;  // h = ((a + m + 1) * (K2 - m)) ^ (b >> 1)
    localparam logic [2:0] OP_P = 3'd3;  // p = b * h
    localparam logic [2:0] OP_Q = 3'd4;  // h = p ^ (h * (m - 1))

    logic [2:0]         state_reg;
    logic [2:0]         op_reg;
    logic [WORD_W-1:0]  cnt_reg;
    logic               out_valid_reg;

    // payload
    logic [WORD_W-1:0]  a_reg;   // holds c until the first product returns
    logic [WORD_W-1:0]  b_reg;
    logic [WORD_W-1:0]  m_reg;
    logic [WORD_W-1:0]  h_reg;
    logic [WORD_W-1:0]  p_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [HALF_W-1:0]  res_reg;
    logic [HALF_W-1:0]  out_data_reg;

    mul_req_t           mul_req;
    logic               mul_done;
    logic [WORD_W-1:0]  mul_result;
    rem_req_t           rem_req;
    logic               rem_done;
    logic [LIMIT_W-1:0] rem_result;

    logic               in_take;
    logic               out_load;
    logic [HALF_W-1:0]  fold;

    assign in_take  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    assign fold     = h_reg[HALF_W-1:0] ^ h_reg[WORD_W-1:HALF_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_req.start = (state_reg == ST_ISSUE);
        unique case (op_reg)
            OP_A:
            begin
                mul_req.op_a = a_reg;
                mul_req.op_b = MIX_K0;
            end
            OP_M:
            begin
                mul_req.op_a = MIX_K3;
                mul_req.op_b = a_reg >> 14;
            end
            OP_T:
            begin
                mul_req.op_a = a_reg + m_reg + 64'd1;
                mul_req.op_b = MIX_K2 - m_reg;
            end
            OP_P:
            begin
                mul_req.op_a = b_reg;
                mul_req.op_b = h_reg;
            end
            OP_Q:
            begin
                mul_req.op_a = h_reg;
                mul_req.op_b = m_reg - 64'd1;
            end
            default:
            begin
                mul_req.op_a = '0;
                mul_req.op_b = '0;
            end
        endcase
    end

    always_comb
    begin
        rem_req.start    = (state_reg == ST_FOLD) && (limit_reg != '0);
        rem_req.dividend = fold[LIMIT_W-1:0];
        rem_req.divisor  = limit_reg;
    end

    chrr_mul64 u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mul_req),
        .done   (mul_done),
        .result (mul_result)
    );

    chrr_rem u_rem (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (rem_req),
        .done      (rem_done),
        .remainder (rem_result)
    );

    // sequencer, counter, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_A;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                cnt_reg <= cfg_data;
            else if (in_take)
                cnt_reg <= cnt_reg + 64'd1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        op_reg    <= OP_A;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                    state_reg <= ST_WAIT;
                ST_WAIT:
                begin
                    if (mul_done)
                    begin
                        if (op_reg == OP_Q)
                            state_reg <= ST_FOLD;
                        else
                        begin
                            op_reg    <= op_reg + 3'd1;
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_FOLD:
                    state_reg <= (limit_reg == '0) ? ST_DONE : ST_REM;
                ST_REM:
                begin
                    if (rem_done)
                        state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_load)
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // hash datapath
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            a_reg     <= cnt_reg;
            b_reg     <= (cnt_reg >> 15) ^ MIX_K1;
            limit_reg <= s_tdata[LIMIT_W-1:0];
        end

        if (state_reg == ST_WAIT && mul_done)
        begin
            case (op_reg)
                OP_A:    a_reg <= mul_result;
                OP_M:    m_reg <= mul_result;
                OP_T:    h_reg <= mul_result ^ (b_reg >> 1);
                OP_P:    p_reg <= mul_result;
                default: h_reg <= p_reg ^ mul_result;
            endcase
        end

        if (state_reg == ST_FOLD && limit_reg == '0)
            res_reg <= fold;
        else if (state_reg == ST_REM && rem_done)
            res_reg <= {1'b0, rem_result};

        if (out_load)
            out_data_reg <= res_reg;
    end

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_tready)
        else $error("request taken while previous still in flight");

    a_mul_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> state_reg == ST_WAIT)
        else $error("product returned outside wait state");

    a_rem_done_waited: assert property (@(posedge clk) disable iff (!rst_n)
        rem_done |-> state_reg == ST_REM)
        else $error("remainder returned outside remainder state");

    a_ranged_result: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_REM && rem_done |-> {1'b0, rem_result} < {1'b0, limit_reg})
        else $error("ranged result not below limit");

endmodule

`default_nettype wire
